### src/antialiased_circle_stepper_top_macros.svh
// ----------------------------------------------------------------------------
// antialiased_circle_stepper_top_macros.svh
// Assertion macros for the circle stepper; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_CIRCLE_STEPPER_TOP_MACROS_SVH
`define ANTIALIASED_CIRCLE_STEPPER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define ACS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ACS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACS_ASSERT_NOW(name, ante, cons, msg)
`define ACS_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

### src/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared widths, codes and the coverage-to-alpha function of the circle stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package acs_pkg;

  localparam int FRAC_BITS  = 4;
  localparam int INT_BITS   = 12;

  localparam int CFG_W      = 16;              // radius and centre fields
  localparam int COORD_W    = 18;              // signed point coordinates
  localparam int MAG_W      = COORD_W - 1;     // magnitude fed to the squarer
  localparam int PROD_W     = 2 * MAG_W;
  localparam int RSQ_W      = 32;
  localparam int ROOT_W     = RSQ_W / 2;
  localparam int SUM_W      = COORD_W + 2;     // centre plus offset
  localparam int PIX_W      = 14;
  localparam int ALPHA_W    = 8;
  localparam int COV_W      = FRAC_BITS + 1;
  localparam int OCT_SHIFT  = 2 * FRAC_BITS + 1;

  localparam int IN_DATA_W  = 2 * CFG_W;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;
  localparam int OUT_PAD_W  = OUT_DATA_W - 3 * PIX_W - 2 * ALPHA_W;
  localparam int USER_PAIR  = 0;
  localparam int USER_DONE  = 1;

  localparam logic [COORD_W-1:0] UNIT_C    = COORD_W'(2 ** FRAC_BITS);
  localparam logic [COV_W-1:0]   COV_ONE   = COV_W'(2 ** FRAC_BITS);
  localparam int                 SCALE_W   = COV_W + ALPHA_W;
  localparam int                 ALPHA_MAX = 2 ** ALPHA_W - 1;
  localparam int                 HALF_LSB  = (2 ** FRAC_BITS) / 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT
  } state_t;

  // how the point moves on a step, or a restart
  typedef enum logic [1:0] {
    OP_RESTART,
    OP_VERT,
    OP_RIGHT,
    OP_LEFT
  } op_t;

  function automatic logic [ALPHA_W-1:0] alpha_of(input logic [COV_W-1:0] cov);
    logic [SCALE_W-1:0] scaled;
    logic [SCALE_W-1:0] shifted;
    scaled  = SCALE_W'(cov) * SCALE_W'(ALPHA_MAX) + SCALE_W'(HALF_LSB);
    shifted = scaled >> FRAC_BITS;
    if (shifted > SCALE_W'(ALPHA_MAX)) begin
      return ALPHA_W'(ALPHA_MAX);
    end
    return shifted[ALPHA_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/acs_square.sv
// ----------------------------------------------------------------------------
// acs_square
// Bit-serial squarer: one multiplier bit per cycle, shift and add.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_square
  import acs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [MAG_W-1:0]  operand,
  output logic                   done,
  output logic [PROD_W-1:0]      product
);

  localparam int CNT_W = $clog2(MAG_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] mcand_r;
  logic [MAG_W-1:0]  mplier_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= PROD_W'(operand);
      mplier_r <= operand;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

### src/acs_isqrt.sv
// ----------------------------------------------------------------------------
// acs_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_isqrt
  import acs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RSQ_W-1:0]  radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;
  localparam int TRY_W = REM_W + 2;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RSQ_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [TRY_W-1:0]  rem_sh;
  logic [TRY_W-1:0]  trial;
  logic [TRY_W-1:0]  diff;
  logic              fits;

  // bring down the next two radicand bits and try appending a one
  always_comb begin
    rem_sh = {rem_r, rad_r[RSQ_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    diff   = rem_sh - trial;
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (fits) begin
        rem_r  <= diff[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

### src/antialiased_circle_stepper_top.sv
// ----------------------------------------------------------------------------
// antialiased_circle_stepper_top
// Anti-aliased circle stepper: emits mirrored pixel pairs with coverage.
// ----------------------------------------------------------------------------
// Usage
//   cfg_wr_en/cfg_wr_data load the radius (unsigned Q12.4); write it while idle.
//   in_* beats: tuser 1 restarts the trace at the top of the circle, tuser 0
//   steps it. Every input beat gives exactly one out_* beat, registered, in the
//   cycle after acceptance: a pixel pair (tuser[0]) for a step, a finished
//   marker (tuser[1]) once the half circle is done, all zeros for a restart.
//   A step or restart keeps the block busy through the bit-serial squarer
//   and then the digit-serial square root; the compare and subtract that
//   feed the root are combinational at the hand-off. A step whose square
//   passes the squared radius skips the root. A step after the end is
//   answered without leaving idle and leaves the state alone.
//   A new input beat is taken once the point update is finished and the
//   output register is free or being drained; a stalled receiver holds the
//   result and backs up the input side, nothing is dropped.
//   Reset (rst_n low, synchronous) clears radius, point and derived terms to
//   zero and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "antialiased_circle_stepper_top_macros.svh"

module antialiased_circle_stepper_top
  import acs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // center_x, center_y
  input  wire logic                  in_tuser,   // req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // left_x, right_x, pixel_y, left_alpha, right_alpha, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]      out_tuser   // pair_valid, done_res
);

  localparam int LIM_PAD = COORD_W - INT_BITS - FRAC_BITS;

  state_t                   state_r, state_nxt;
  op_t                      op_r;
  logic [CFG_W-1:0]         radius_r;
  logic [COORD_W-1:0]       px_r;
  logic [COORD_W-1:0]       py_r;
  logic [RSQ_W-1:0]         rsq_r;
  logic [INT_BITS-1:0]      lim_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0]    out_user_r;

  logic                     in_fire;
  logic                     finished;
  logic [CFG_W-1:0]         cx, cy;
  logic signed [SUM_W-1:0]  cx_s, cy_s, x_s, y_s;
  logic signed [SUM_W-1:0]  lo_v, hi_v, pyv_v;
  logic                     is_vert;
  logic [COV_W-1:0]         cov_l, cov_r, cov_y;
  logic [ALPHA_W-1:0]       alpha_l, alpha_r;
  logic [COORD_W-1:0]       new_coord;
  logic [COORD_W-1:0]       new_neg;
  op_t                      new_op;
  logic [MAG_W-1:0]         sq_operand;

  logic                     sq_start, sq_done;
  logic [PROD_W-1:0]        sq_prod;
  logic                     sq_over;
  logic                     rt_start, rt_done;
  logic [RSQ_W-1:0]         rt_radicand;
  logic [ROOT_W-1:0]        rt_root;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign finished  = px_r[COORD_W-1];
  assign cx        = in_tdata[CFG_W-1:0];
  assign cy        = in_tdata[IN_DATA_W-1:CFG_W];

  // pixel pair of the current point
  always_comb begin
    cx_s    = $signed({{(SUM_W-CFG_W){1'b0}}, cx});
    cy_s    = $signed({{(SUM_W-CFG_W){1'b0}}, cy});
    x_s     = $signed({{(SUM_W-COORD_W){px_r[COORD_W-1]}}, px_r});
    y_s     = $signed({{(SUM_W-COORD_W){py_r[COORD_W-1]}}, py_r});
    lo_v    = cx_s - x_s;
    hi_v    = cx_s + x_s;
    pyv_v   = cy_s + y_s;
    is_vert = $signed(px_r) >= $signed({{LIM_PAD{1'b0}}, lim_r, {FRAC_BITS{1'b0}}});
    cov_l   = COV_ONE - {1'b0, lo_v[FRAC_BITS-1:0]};
    cov_r   = {1'b0, hi_v[FRAC_BITS-1:0]};
    if (py_r[COORD_W-1]) begin
      cov_y = COV_ONE - {1'b0, pyv_v[FRAC_BITS-1:0]};
    end else begin
      cov_y = {1'b0, pyv_v[FRAC_BITS-1:0]};
    end
    alpha_l = is_vert ? alpha_of(cov_l) : alpha_of(cov_y);
    alpha_r = is_vert ? alpha_of(cov_r) : alpha_of(cov_y);
  end

  // coordinate that moves by one unit, and the magnitude to square
  always_comb begin
    if (in_tuser) begin
      new_op    = OP_RESTART;
      new_coord = '0;
    end else if (is_vert) begin
      new_op    = OP_VERT;
      new_coord = py_r + UNIT_C;
    end else if (py_r[COORD_W-1]) begin
      new_op    = OP_RIGHT;
      new_coord = px_r + UNIT_C;
    end else begin
      new_op    = OP_LEFT;
      new_coord = px_r - UNIT_C;
    end
    new_neg = -new_coord;
    if (in_tuser) begin
      sq_operand = MAG_W'(radius_r);
    end else if (new_coord[COORD_W-1]) begin
      sq_operand = new_neg[MAG_W-1:0];
    end else begin
      sq_operand = new_coord[MAG_W-1:0];
    end
  end

  assign sq_over = sq_prod > PROD_W'(rsq_r);

  always_comb begin
    if (op_r == OP_RESTART) begin
      rt_radicand = sq_prod[RSQ_W-1:0] >> OCT_SHIFT;
    end else begin
      rt_radicand = rsq_r - sq_prod[RSQ_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser || !finished)) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_done) begin
          state_nxt = (op_r == OP_RESTART || !sq_over) ? ST_ROOT : ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (rt_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // unit starts
  always_comb begin
    sq_start = 1'b0;
    rt_start = 1'b0;
    unique case (state_r)
      ST_IDLE:   sq_start = in_fire && (in_tuser || !finished);
      ST_SQUARE: rt_start = sq_done && (op_r == OP_RESTART || !sq_over);
      ST_ROOT:   ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // point and derived terms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r  <= '0;
      py_r  <= '0;
      rsq_r <= '0;
      lim_r <= '0;
      op_r  <= OP_RESTART;
    end else begin
      if (state_r == ST_IDLE && in_fire && (in_tuser || !finished)) begin
        op_r <= new_op;
        unique case (new_op)
          OP_RESTART: begin
            px_r <= '0;
            py_r <= -COORD_W'(radius_r);
          end
          OP_VERT:            py_r <= new_coord;
          OP_RIGHT, OP_LEFT:  px_r <= new_coord;
          default:            ;
        endcase
      end
      if (state_r == ST_SQUARE && sq_done) begin
        if (op_r == OP_RESTART) begin
          rsq_r <= sq_prod[RSQ_W-1:0];
        end else if (sq_over) begin
          // run went past the radius: mark the end, or clamp the root to zero
          if (op_r == OP_VERT) begin
            px_r <= -UNIT_C;
          end else begin
            py_r <= '0;
          end
        end
      end
      if (state_r == ST_ROOT && rt_done) begin
        unique case (op_r)
          OP_RESTART: lim_r <= rt_root[INT_BITS-1:0];
          OP_VERT:    px_r  <= COORD_W'(rt_root);
          OP_RIGHT:   py_r  <= -COORD_W'(rt_root);
          OP_LEFT:    py_r  <= COORD_W'(rt_root);
          default:    ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_tuser) begin
        out_data_r <= '0;
        out_user_r <= '0;
      end else if (finished) begin
        out_data_r <= '0;
        out_user_r <= OUT_USER_W'(1) << USER_DONE;
      end else begin
        out_data_r <= {{OUT_PAD_W{1'b0}}, alpha_r, alpha_l,
                       pyv_v[FRAC_BITS +: PIX_W], hi_v[FRAC_BITS +: PIX_W],
                       lo_v[FRAC_BITS +: PIX_W]};
        out_user_r <= OUT_USER_W'(1) << USER_PAIR;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  acs_square u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_operand),
    .done    (sq_done),
    .product (sq_prod)
  );

  acs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (rt_radicand),
    .done     (rt_done),
    .root     (rt_root)
  );

  `ACS_ASSERT_NOW(a_sq_done_phase, sq_done, state_r == ST_SQUARE, "square done off phase")
  `ACS_ASSERT_NOW(a_rt_done_phase, rt_done, state_r == ST_ROOT, "root done off phase")
  `ACS_ASSERT_NEXT(a_restart, in_fire && in_tuser, px_r == '0 && state_r == ST_SQUARE, "reload")
  `ACS_ASSERT_NEXT(a_fin_idle, in_fire && !in_tuser && finished, state_r == ST_IDLE, "left idle")
  `ACS_ASSERT_NEXT(a_fin_beat, in_fire && !in_tuser && finished, out_user_r[USER_DONE], "no done")

endmodule

`default_nettype wire
